[rtl/md5bf_pkg.sv]
// Package for the MD5 preimage search block: widths, codes, round tables.
// No dependencies.
package md5bf_pkg;
  localparam int MaxSymbols  = 64;
  localparam int MaxKeyBytes = 7;
  localparam int SymW        = $clog2(MaxSymbols);

  localparam logic [1:0] ModeLoadSym = 2'd0;
  localparam logic [1:0] ModeLoadDig = 2'd1;
  localparam logic [1:0] ModeStart   = 2'd2;

  localparam logic CfgSymbolCount = 1'b0;
  localparam logic CfgLongestKey  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BUILD, ST_ROUND, ST_CHECK, ST_NEXT, ST_DONE
  } state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
          32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
          32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
          32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
          32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
          32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
          32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
          32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
          32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
          32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
          32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] t [16];
    t = '{5'd7,5'd12,5'd17,5'd22,5'd5,5'd9,5'd14,5'd20,
          5'd4,5'd11,5'd16,5'd23,5'd6,5'd10,5'd15,5'd21};
    return t[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction
endpackage

[rtl/md5bf_if.sv]
// Valid/ready channel interfaces for the search block.
// No dependencies.
interface md5bf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  slot;
  logic [31:0] data_value;
  modport source (output valid, mode, slot, data_value, input ready);
  modport sink   (input valid, mode, slot, data_value, output ready);
endinterface

interface md5bf_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [2:0]  key_length;
  logic [55:0] key_bytes;
  modport source (output valid, status, key_length, key_bytes, input ready);
  modport sink   (input valid, status, key_length, key_bytes, output ready);
endinterface

interface md5bf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/md5bf_round.sv]
// One MD5 round step: the shared unit the sequencer reuses 64 times.
// Depends on md5bf_pkg.
module md5bf_round (
  input  logic [5:0]  rnd,
  input  logic [31:0] a, b, c, d,
  input  logic [31:0] m,
  output logic [31:0] b_new,
  output logic [3:0]  g
);
  import md5bf_pkg::*;
  logic [31:0] f, sum;
  logic [4:0]  s;
  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * rnd + 1); end
      2'd2: begin f = b ^ c ^ d;           g = 4'(3 * rnd + 5); end
      default: begin f = c ^ (b | ~d);     g = 4'(7 * rnd); end
    endcase
    s     = md5_s(rnd);
    sum   = a + f + md5_k(rnd) + m;
    b_new = b + ((sum << s) | (sum >> (6'd32 - {1'b0, s})));
  end
endmodule

[rtl/md5_preimage_brute_search.sv]
// MD5 preimage brute-force search: top level with sequencer and odometer.
// Depends on md5bf_pkg, md5bf_if, md5bf_round.
// Load items are accepted while idle. A search handles each candidate of length len
// in order: key build (one alphabet read per key byte), 64 rounds of the shared
// round unit, check, advance. Not ready while searching. Synchronous
// active-low reset clears control and sets longest_key to 7; alphabet and digest
// are undefined until written.
module md5_preimage_brute_search (
  input logic clk,
  input logic rst_n,
  md5bf_in_if.sink    in_ch,
  md5bf_out_if.source out_ch,
  md5bf_cfg_if.sink   cfg_ch
);
  import md5bf_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0]  alpha_r [MaxSymbols];
  logic [7:0]  alpha_q_r;
  logic [31:0] dig_r [4];
  logic [6:0]  nsym_r;
  logic [2:0]  maxlen_r;
  logic [SymW-1:0] pos_r [MaxKeyBytes];
  logic [2:0]  len_r;
  logic [2:0]  bld_r;
  logic [5:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [511:0] blk_r;
  logic        res_status_r;
  logic [2:0]  res_len_r;
  logic [55:0] res_key_r;

  logic [31:0] b_new, m_word;
  logic [3:0]  g;
  logic [31:0] h0, h1, h2, h3;
  logic        match;
  logic        carry_all;
  logic [6:0]  nsym_sat;
  logic [2:0]  maxlen_sat;
  logic [511:0] blk_init;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign nsym_sat   = (nsym_r > 7'(MaxSymbols)) ? 7'(MaxSymbols) : nsym_r;
  assign maxlen_sat = (maxlen_r > 3'(MaxKeyBytes)) ? 3'(MaxKeyBytes) : maxlen_r;

  md5bf_round u_round (
    .rnd(rnd_r), .a(a_r), .b(b_r), .c(c_r), .d(d_r),
    .m(m_word), .b_new(b_new), .g(g)
  );
  assign m_word = blk_r[32*g +: 32];

  // padding and length of the block; key bytes are filled in afterwards
  always_comb begin
    blk_init = '0;
    blk_init[8*len_r +: 8] = 8'h80;
    blk_init[448 +: 8] = {2'b00, len_r, 3'b000};
  end

  // final digest and compare
  assign h0 = 32'h67452301 + a_r;
  assign h1 = 32'hefcdab89 + b_r;
  assign h2 = 32'h98badcfe + c_r;
  assign h3 = 32'h10325476 + d_r;
  assign match = (swap32(h0) == dig_r[0]) && (swap32(h1) == dig_r[1]) &&
                 (swap32(h2) == dig_r[2]) && (swap32(h3) == dig_r[3]);

  // every active digit at its top value: length exhausted
  always_comb begin
    carry_all = 1'b1;
    for (int i = 0; i < MaxKeyBytes; i++) begin
      if (3'(i) < len_r && 7'(pos_r[i]) + 7'd1 < nsym_sat) carry_all = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid && in_ch.mode == ModeStart) begin
                  state_nxt = (nsym_sat == 7'd0 || maxlen_sat == 3'd0) ? ST_DONE : ST_BUILD;
                end
      ST_BUILD: if (bld_r == len_r) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = match ? ST_DONE : ST_NEXT;
      ST_NEXT:  state_nxt = (carry_all && len_r == maxlen_sat) ? ST_DONE : ST_BUILD;
      ST_DONE:  if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_ch.valid      = (state_r == ST_DONE);
    out_ch.status     = res_status_r;
    out_ch.key_length = res_len_r;
    out_ch.key_bytes  = res_key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      nsym_r   <= '0;
      maxlen_r <= 3'd7;
      len_r    <= '0;
      bld_r    <= '0;
      rnd_r    <= '0;
      for (int i = 0; i < MaxKeyBytes; i++) pos_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CfgSymbolCount) nsym_r <= cfg_ch.data[6:0];
        else maxlen_r <= cfg_ch.data[2:0];
      end
      unique case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          if (in_ch.mode == ModeLoadSym) alpha_r[in_ch.slot] <= in_ch.data_value[7:0];
          else if (in_ch.mode == ModeLoadDig && in_ch.slot < 6'd4)
            dig_r[in_ch.slot[1:0]] <= in_ch.data_value;
          else if (in_ch.mode == ModeStart) begin
            res_status_r <= 1'b1;
            res_len_r    <= '0;
            res_key_r    <= '0;
            len_r        <= 3'd1;
            bld_r        <= '0;
            for (int i = 0; i < MaxKeyBytes; i++) pos_r[i] <= '0;
          end
        end
        ST_BUILD: begin
          // padded block from current digits, one alphabet read per cycle
          if (bld_r == 3'd0) begin
            blk_r <= blk_init;
            a_r <= 32'h67452301; b_r <= 32'hefcdab89;
            c_r <= 32'h98badcfe; d_r <= 32'h10325476;
            rnd_r <= '0;
          end else begin
            blk_r[8*(bld_r - 3'd1) +: 8] <= alpha_q_r;
          end
          if (bld_r < len_r) alpha_q_r <= alpha_r[pos_r[bld_r]];
          bld_r <= bld_r + 3'd1;
        end
        ST_ROUND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_new;
          if (rnd_r != 6'd63) rnd_r <= rnd_r + 6'd1;
        end
        ST_CHECK: if (match) begin
          res_status_r <= 1'b0;
          res_len_r    <= len_r;
          res_key_r    <= blk_r[55:0] &
                          ((56'd1 << {len_r, 3'b000}) - 56'd1);
        end
        ST_NEXT: begin
          // odometer advance, last digit fastest
          bld_r <= '0;
          if (carry_all) begin
            for (int i = 0; i < MaxKeyBytes; i++) pos_r[i] <= '0;
            if (len_r != maxlen_sat) len_r <= len_r + 3'd1;
          end else begin
            logic stop;
            stop = 1'b0;
            for (int i = MaxKeyBytes - 1; i >= 0; i--) begin
              if (!stop && 3'(i) < len_r) begin
                if (7'(pos_r[i]) + 7'd1 < nsym_sat) begin
                  pos_r[i] <= pos_r[i] + 1'b1;
                  stop = 1'b1;
                end else pos_r[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result only after a search ends, or after a start with no symbols or zero longest key
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !$past(out_ch.valid) |-> $past(state_r == ST_CHECK || state_r == ST_NEXT
      || state_r == ST_IDLE))
    else $error("result without search");
  // found result carries nonzero length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.status |-> out_ch.key_length != 3'd0)
    else $error("found key with zero length");
  // not-found result carries all-zero key bytes
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.key_bytes == 56'd0)
    else $error("not-found key nonzero");
endmodule
